// ----- hdl/rdsm_pkg.sv -----
`default_nettype none
package rdsm_pkg;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE = 8'h2E;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TEXT = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	// per-word command broadcast to every cell
	typedef struct packed {
		logic text;       // advance the active set by one text byte
		logic store;      // write a new element at the current count
		logic set_star;   // mark the last element as starred
		logic [7:0] pbyte; // pattern byte or text byte
	} cell_ctl_t;

	// neighbor link between adjacent cells
	typedef struct packed {
		logic adv;   // prefix advanced past a plain element
		logic carry; // closure through a starred element
	} link_t;

endpackage
`default_nettype wire

// ----- hdl/rdsm_cell.sv -----
`default_nettype none
module rdsm_cell #(
	parameter int IDX = 0,
	parameter int CNT_W = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire rdsm_pkg::cell_ctl_t ctl,
	input wire logic [CNT_W-1:0] count_q,
	input wire logic [CNT_W-1:0] count_next,
	input wire rdsm_pkg::link_t link_in,
	output rdsm_pkg::link_t link_out,
	output logic active_out
);

	logic [7:0] byte_q;
	logic any_q;
	logic star_q;
	logic active_q;

	logic store_here;
	logic star_here;
	logic [7:0] byte_n;
	logic any_n;
	logic star_n;
	logic used_n;
	logic takes;
	logic nxt;
	logic fin;

	always_comb begin
		store_here = ctl.store && (count_q == CNT_W'(IDX));
		star_here = ctl.set_star && (count_q == CNT_W'(IDX + 1));
		byte_n = store_here ? ctl.pbyte : byte_q;
		any_n = store_here ? (ctl.pbyte == rdsm_pkg::DOT_BYTE) : any_q;
		star_n = store_here ? 1'b0 : (star_here ? 1'b1 : star_q);
		used_n = CNT_W'(IDX) < count_next;
		takes = any_n || (byte_n == ctl.pbyte);
		// restart, clear and append put only the empty prefix in the set, before star closure
		if (ctl.text) begin
			nxt = (used_n && active_q && takes && star_n) || link_in.adv;
		end else begin
			nxt = (IDX == 0);
		end
		fin = nxt || link_in.carry;
		link_out.adv = ctl.text && used_n && active_q && takes && !star_n;
		link_out.carry = used_n && star_n && fin;
		active_out = fin;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= byte_n;
			any_q <= any_n;
			star_q <= star_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (IDX == 0);
		end else if (accept) begin
			active_q <= fin;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/regex_dot_star_full_match_unit.sv -----
`default_nettype none
// Whole-text matcher for patterns of literal bytes, '.' (any byte) and '*' (zero or
// more of the element before it). Every input word carries a kind: clear pattern,
// append pattern byte, text byte or restart text; every word gives exactly one result
// word with matched (text since last restart matches the whole pattern), pattern_full
// (sticky, a pattern byte was dropped for lack of room) and pattern_bad (sticky, leading
// or doubled star; nothing matches while set). Appending a pattern byte also restarts
// the text. The pattern lives in a row of MAX_ELEMENTS cells, one per element, each
// holding its element and the active bit of the prefix in front of it. A word is taken
// every cycle that in_stall is low and its result is registered into the output buffer, so
// the block runs at one word per clock while not stalled. The longest path is the
// star closure rippling from cell to cell along the whole row, so its length grows with
// MAX_ELEMENTS. A two-deep output buffer lets a word be taken while a result still
// waits; in_stall rises only when both result slots are full.
module regex_dot_star_full_match_unit #(
	parameter int MAX_ELEMENTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic matched,
	output logic pattern_full,
	output logic pattern_bad
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	// pattern bookkeeping
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic bad_q;
	logic bad_next;
	logic full_q;
	logic full_next;
	logic last_star_q;
	logic last_star_next;

	logic accept;
	rdsm_pkg::cell_ctl_t ctl;
	rdsm_pkg::kind_t kind_w;
	logic is_star;
	logic at_cap;

	// cell row
	rdsm_pkg::link_t links [0:MAX_ELEMENTS];
	logic [MAX_ELEMENTS:0] final_vec;
	logic matched_n;

	// output buffer: main slot plus skid slot
	logic out_valid_q;
	logic matched_q;
	logic full_out_q;
	logic bad_out_q;
	logic skid_valid_q;
	logic skid_matched_q;
	logic skid_full_q;
	logic skid_bad_q;
	logic pop;

	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign pop = out_valid_q && !out_stall;

	always_comb begin
		kind_w = rdsm_pkg::kind_t'(kind);
		is_star = (data_byte == rdsm_pkg::STAR_BYTE);
		at_cap = (count_q == CNT_W'(MAX_ELEMENTS));

		ctl.text = 1'b0;
		ctl.store = 1'b0;
		ctl.set_star = 1'b0;
		ctl.pbyte = data_byte;
		count_next = count_q;
		bad_next = bad_q;
		full_next = full_q;
		last_star_next = last_star_q;

		case (kind_w)
			rdsm_pkg::KIND_CLEAR: begin
				count_next = '0;
				bad_next = 1'b0;
				full_next = 1'b0;
				last_star_next = 1'b0;
			end
			rdsm_pkg::KIND_APPEND: begin
				// once full, every pattern byte is dropped, stars too
				if (!full_q) begin
					if (is_star) begin
						if ((count_q == '0) || last_star_q) begin
							bad_next = 1'b1;
						end else begin
							ctl.set_star = 1'b1;
							last_star_next = 1'b1;
						end
					end else if (at_cap) begin
						full_next = 1'b1;
					end else begin
						ctl.store = 1'b1;
						count_next = count_q + CNT_W'(1);
						last_star_next = 1'b0;
					end
				end
			end
			rdsm_pkg::KIND_TEXT: begin
				ctl.text = 1'b1;
			end
			rdsm_pkg::KIND_RESTART: begin
				ctl.text = 1'b0;
			end
			default: begin
				ctl.text = 1'b0;
			end
		endcase
	end

	// nothing flows into the first cell
	assign links[0] = '0;

	genvar g;
	generate
		for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
			rdsm_cell #(
				.IDX(g),
				.CNT_W(CNT_W)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.accept(accept),
				.ctl(ctl),
				.count_q(count_q),
				.count_next(count_next),
				.link_in(links[g]),
				.link_out(links[g+1]),
				.active_out(final_vec[g])
			);
		end
	endgenerate

	// prefix past the last possible element has no element of its own
	assign final_vec[MAX_ELEMENTS] = links[MAX_ELEMENTS].adv || links[MAX_ELEMENTS].carry;

	// whole pattern consumed: the prefix at the element count is active
	assign matched_n = !bad_next && final_vec[count_next];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bad_q <= 1'b0;
			full_q <= 1'b0;
			last_star_q <= 1'b0;
		end else if (accept) begin
			count_q <= count_next;
			bad_q <= bad_next;
			full_q <= full_next;
			last_star_q <= last_star_next;
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				matched_q <= skid_matched_q;
				full_out_q <= skid_full_q;
				bad_out_q <= skid_bad_q;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_matched_q <= matched_n;
				skid_full_q <= full_next;
				skid_bad_q <= bad_next;
			end else begin
				matched_q <= matched_n;
				full_out_q <= full_next;
				bad_out_q <= bad_next;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign matched = matched_q;
	assign pattern_full = full_out_q;
	assign pattern_bad = bad_out_q;

endmodule
`default_nettype wire

// ----- dv/regex_dot_star_full_match_unit_tb.sv -----
`default_nettype none
module regex_dot_star_full_match_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ELEMENTS = 32;
	localparam int WORD_TARGET = 1450;
	localparam int CALM_FROM = 1250;   // no idling on either side past this word count
	localparam int HOLD_AT = 400;      // long receiver hold-off starts here
	localparam int DRAIN_AT = 800;     // sender waits for every result here
	localparam int LONG_HOLD = 80;

	// expected result word: one per accepted input word
	typedef struct packed {
		logic matched;
		logic full;
		logic bad;
	} verdict_t;

	// predicts the matcher state word by word and checks the result stream in order
	class match_scoreboard #(int CAP = 32);
		logic [7:0] elem_byte [CAP];
		bit elem_any [CAP];
		bit elem_star [CAP];
		int unsigned elem_count;
		bit active [CAP+1];
		bit bad_seen;
		bit full_seen;
		verdict_t verdict_q [$];
		int errors;
		int results;
		int match_hits;
		int full_hits;
		int bad_hits;

		function new();
			for (int e = 0; e < CAP; e++) begin
				elem_byte[e] = 8'h00;
				elem_any[e] = 1'b0;
				elem_star[e] = 1'b0;
			end
			elem_count = 0;
			bad_seen = 1'b0;
			full_seen = 1'b0;
			errors = 0;
			results = 0;
			match_hits = 0;
			full_hits = 0;
			bad_hits = 0;
			restart_text();
		endfunction

		// epsilon edges of starred elements, ascending so chains of stars close in one pass
		function void close_stars();
			for (int e = 0; e < elem_count; e++) begin
				if (active[e] && elem_star[e])
					active[e+1] = 1'b1;
			end
		endfunction

		function void restart_text();
			for (int e = 0; e <= CAP; e++)
				active[e] = 1'b0;
			active[0] = 1'b1;
			close_stars();
		endfunction

		function void add_pattern_byte(logic [7:0] b);
			if (full_seen)
				return;
			if (b == rdsm_pkg::STAR_BYTE) begin
				if (elem_count == 0 || elem_star[elem_count-1])
					bad_seen = 1'b1;
				else
					elem_star[elem_count-1] = 1'b1;
			end else if (elem_count >= CAP) begin
				full_seen = 1'b1;
			end else begin
				elem_byte[elem_count] = b;
				elem_any[elem_count] = (b == rdsm_pkg::DOT_BYTE);
				elem_star[elem_count] = 1'b0;
				elem_count++;
			end
		endfunction

		function void advance_text(logic [7:0] c);
			bit nxt [CAP+1];
			for (int e = 0; e <= CAP; e++)
				nxt[e] = 1'b0;
			for (int e = 0; e < elem_count; e++) begin
				if (active[e] && (elem_any[e] || elem_byte[e] == c)) begin
					if (elem_star[e])
						nxt[e] = 1'b1;
					else
						nxt[e+1] = 1'b1;
				end
			end
			active = nxt;
			close_stars();
		endfunction

		function void note_word(rdsm_pkg::kind_t k, logic [7:0] b);
			verdict_t v;
			case (k)
				rdsm_pkg::KIND_CLEAR: begin
					elem_count = 0;
					bad_seen = 1'b0;
					full_seen = 1'b0;
					restart_text();
				end
				rdsm_pkg::KIND_APPEND: begin
					add_pattern_byte(b);
					restart_text();
				end
				rdsm_pkg::KIND_TEXT: advance_text(b);
				default: restart_text();
			endcase
			v.matched = !bad_seen && active[elem_count];
			v.full = full_seen;
			v.bad = bad_seen;
			verdict_q.push_back(v);
		endfunction

		function void check_result(logic m, logic f, logic bd);
			verdict_t v;
			results++;
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: m=%0b f=%0b b=%0b", m, f, bd);
				return;
			end
			v = verdict_q.pop_front();
			if (m !== v.matched || f !== v.full || bd !== v.bad) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at result %0d: expected m=%0b f=%0b b=%0b, got m=%0b f=%0b b=%0b",
						results, v.matched, v.full, v.bad, m, f, bd);
			end
			if (m === 1'b1)
				match_hits++;
			if (f === 1'b1)
				full_hits++;
			if (bd === 1'b1)
				bad_hits++;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = 2'd0;
	logic [7:0] data_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic matched;
	logic pattern_full;
	logic pattern_bad;

	match_scoreboard #(NUM_ELEMENTS) sb;

	// stimulus-side knobs
	bit calm = 1'b0;          // end of run: no idling anywhere
	bit rushing = 1'b0;       // sender offers back to back while the receiver holds off
	bit long_hold_req = 1'b0; // handed to the receiver, cleared by it
	bit held = 1'b0;          // long hold-off already requested
	bit drained = 1'b0;       // sender already waited for the result stream
	int tx_mode = 0;          // 0 no sender gaps, 1 occasional bursts
	int words_sent = 0;

	regex_dot_star_full_match_unit #(
		.MAX_ELEMENTS(NUM_ELEMENTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched(matched),
		.pattern_full(pattern_full),
		.pattern_bad(pattern_bad)
	);

	always #5 clk = ~clk;

	// hard stop in case the handshake hangs
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: every word taken at this edge is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(matched, pattern_full, pattern_bad);
	end

	// receiver stall pattern: quiet stretches, rare bursts, busy stretches, one long hold-off
	initial begin
		int stall_left;
		int rx_mode;
		int mode_left;
		stall_left = 0;
		rx_mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 250);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				// long hold-off so the output buffer fills and the input backs up
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (!calm && rx_mode != 0 &&
					$urandom_range(0, (rx_mode == 1) ? 15 : 3) == 0) begin
				stall_left = $urandom_range(0, 18);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// one input word, with an optional idle burst in front of it
	task automatic send_word(rdsm_pkg::kind_t k, logic [7:0] b);
		if (!calm && !rushing && tx_mode != 0 && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(k, b);
		words_sent++;
	endtask

	task automatic send_pattern(string s);
		for (int i = 0; i < s.len(); i++)
			send_word(rdsm_pkg::KIND_APPEND, s[i]);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_word(rdsm_pkg::KIND_TEXT, s[i]);
	endtask

	// sender stops offering until the result stream has caught up
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// mostly small alphabet so texts and patterns collide often
	function automatic logic [7:0] pick_pattern_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return "a";
		else if (r < 6)
			return "b";
		else if (r < 8)
			return rdsm_pkg::DOT_BYTE;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// random pattern, then a few texts built to walk it, some of them damaged
	task automatic run_sequence();
		logic [7:0] pat_byte [$];
		bit pat_star [$];
		logic [7:0] txt [$];
		int n;
		int reps;
		int cut;
		logic [7:0] b;
		tx_mode = $urandom_range(0, 1);
		send_word(rdsm_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)));
		// a tenth of the patterns are sized around the element store, some running past it
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(NUM_ELEMENTS - 4, NUM_ELEMENTS + 4);
		else
			n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			pat_byte.push_back(pick_pattern_byte());
			pat_star.push_back($urandom_range(0, 2) == 0);
		end
		// broken patterns: leading star or doubled star
		if ($urandom_range(0, 7) == 0)
			send_word(rdsm_pkg::KIND_APPEND, rdsm_pkg::STAR_BYTE);
		for (int i = 0; i < n; i++) begin
			send_word(rdsm_pkg::KIND_APPEND, pat_byte[i]);
			if (pat_star[i]) begin
				send_word(rdsm_pkg::KIND_APPEND, rdsm_pkg::STAR_BYTE);
				if ($urandom_range(0, 15) == 0)
					send_word(rdsm_pkg::KIND_APPEND, rdsm_pkg::STAR_BYTE);
			end
		end
		reps = $urandom_range(1, 4);
		for (int r = 0; r < reps; r++) begin
			if (r != 0 || $urandom_range(0, 3) == 0)
				send_word(rdsm_pkg::KIND_RESTART, 8'($urandom_range(0, 255)));
			txt.delete();
			for (int i = 0; i < n; i++) begin
				cut = pat_star[i] ? $urandom_range(0, 3) : 1;
				for (int j = 0; j < cut; j++)
					txt.push_back((pat_byte[i] == rdsm_pkg::DOT_BYTE) ?
						8'($urandom_range(0, 255)) : pat_byte[i]);
			end
			case ($urandom_range(0, 7))
				0: if (txt.size() != 0)
					txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
				1: txt.push_back(pick_pattern_byte());
				2: if (txt.size() != 0)
					txt.delete($urandom_range(0, txt.size() - 1));
				default: ;
			endcase
			foreach (txt[i]) begin
				send_word(rdsm_pkg::KIND_TEXT, txt[i]);
				// occasional noise word in the middle of a text
				if ($urandom_range(0, 29) == 0) begin
					b = 8'($urandom_range(0, 255));
					send_word(rdsm_pkg::kind_t'($urandom_range(0, 3)), b);
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pattern against empty and nonempty text
		send_word(rdsm_pkg::KIND_RESTART, 8'h00);
		send_word(rdsm_pkg::KIND_TEXT, 8'hFF);
		// leading star poisons the pattern, text still tracked
		send_word(rdsm_pkg::KIND_APPEND, rdsm_pkg::STAR_BYTE);
		send_word(rdsm_pkg::KIND_TEXT, "a");
		send_word(rdsm_pkg::KIND_CLEAR, 8'hFF);
		// doubled star
		send_pattern("a**");
		send_text("a");
		send_word(rdsm_pkg::KIND_CLEAR, 8'h00);
		// literal, dot-star, literal
		send_pattern("a.*b");
		send_text("axyb");
		send_word(rdsm_pkg::KIND_RESTART, 8'hFF);
		send_text("ab");
		// extreme byte values as literals
		send_word(rdsm_pkg::KIND_CLEAR, 8'h55);
		send_word(rdsm_pkg::KIND_APPEND, 8'hFF);
		send_word(rdsm_pkg::KIND_APPEND, 8'h00);
		send_word(rdsm_pkg::KIND_TEXT, 8'hFF);
		send_word(rdsm_pkg::KIND_TEXT, 8'h00);
		send_word(rdsm_pkg::KIND_TEXT, 8'h00);

		// random part with the two pressure points on the way
		while (words_sent < WORD_TARGET) begin
			if (words_sent >= CALM_FROM)
				calm = 1'b1;
			if (!held && words_sent >= HOLD_AT) begin
				held = 1'b1;
				rushing = 1'b1;
				long_hold_req = 1'b1;
				run_sequence();
				run_sequence();
				rushing = 1'b0;
			end else if (!drained && words_sent >= DRAIN_AT) begin
				drained = 1'b1;
				wait_for_results();
				run_sequence();
			end else begin
				run_sequence();
			end
		end
		calm = 1'b1;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d words sent, %0d results checked, %0d mismatches", words_sent,
			sb.results, sb.errors);
		$display("results with match %0d, with store full %0d, with bad pattern %0d",
			sb.match_hits, sb.full_hits, sb.bad_hits);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/rdsm_pkg.sv
hdl/rdsm_cell.sv
hdl/regex_dot_star_full_match_unit.sv
dv/regex_dot_star_full_match_unit_tb.sv
